// ----- sv/light_sensor_auto_range_lux_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the lux converter
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_AUTO_RANGE_LUX_UNIT_ASSERT_SVH
`define LIGHT_SENSOR_AUTO_RANGE_LUX_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset
`define LSAR_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define LSAR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define LSAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lsar_pkg.sv -----
// ---------------------------------------------------------------------------
// lsar_pkg
// Types, constants and helper functions of the auto-ranging lux converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsar_pkg;

    // Field widths
    localparam int RAW_W      = 16;
    localparam int LUX_W      = 48;
    localparam int GAIN_W     = 2;
    localparam int TIME_W     = 3;
    localparam int KIND_W     = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int SCALED_W = 22;   // 36 * raw count
    localparam int SHIFT_W  = 5;    // total scale shift, up to 25
    localparam int NUM_W    = 48;   // rounded numerator, becomes quotient
    localparam int REM_W    = 14;   // remainder below the divisor
    localparam int DIG_W    = 4;    // one radix-16 quotient digit
    localparam int PART_W   = REM_W + DIG_W;
    localparam int L_W      = 33;   // base lux in Q16
    localparam int LO_W     = 16;   // low half of base lux for the multiplier
    localparam int X_W      = 44;   // Horner coefficient register
    localparam int MB_W     = L_W - LO_W + 1;
    localparam int PROD_W   = X_W + MB_W;
    localparam int ACC_W    = 77;   // full Horner product
    localparam int H1_LSB   = 32;
    localparam int H2_LSB   = 28;
    localparam int H3_LSB   = 16;
    localparam int FIN_LSB  = 32;
    localparam int CNT_W    = 4;

    // Sequencer lengths
    localparam logic [CNT_W-1:0] DIV_LAST  = 4'd11;  // 12 radix-16 steps
    localparam logic [CNT_W-1:0] POLY_LAST = 4'd12;  // 13 Horner steps

    // Step limits and auto start point
    localparam logic [GAIN_W-1:0] GAIN_STEP_TOP   = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_AUTO_START = 2'd0;
    localparam logic [TIME_W-1:0] TIME_MAX        = 3'd5;
    localparam logic [TIME_W-1:0] TIME_AUTO_START = 3'd2;
    localparam logic [SHIFT_W-1:0] Q16_SHIFT      = 5'd16;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] CFG_GAIN_RST = 2'd0;
    localparam logic [TIME_W-1:0] CFG_TIME_RST = 3'd2;
    localparam logic [RAW_W-1:0]  CFG_LOW_RST  = 16'd100;
    localparam logic [RAW_W-1:0]  CFG_HIGH_RST = 16'd10000;

    // Rounded division by 10000
    localparam logic [PART_W-1:0] DIVISOR    = 18'd10000;
    localparam logic [NUM_W-1:0]  ROUND_BIAS = 48'd5000;

    // Correction polynomial coefficients
    localparam logic [X_W-1:0]   CA4        = 44'd693309;
    localparam logic [X_W-1:0]   CA3        = 44'd165233;
    localparam logic [ACC_W-1:0] CA2        = 77'd93949267567403;
    localparam logic [ACC_W-1:0] CA1        = 77'd282122369157091;
    localparam logic [ACC_W-1:0] FINAL_BIAS = 77'd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MANUAL_GAIN = 2'd0,
        REG_MANUAL_TIME = 2'd1,
        REG_LOW_LIMIT   = 2'd2,
        REG_HIGH_LIMIT  = 2'd3
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_START_AUTO   = 2'd0,
        OP_AUTO_SAMPLE  = 2'd1,
        OP_MANUAL_PLAIN = 2'd2,
        OP_MANUAL_CORR  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPLY  = 2'd0,
        KIND_LUX    = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FIRST   = 2'd1,
        PH_RAISE   = 2'd2,
        PH_SHORTEN = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_DIV,
        ST_POLY,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        LUX_ZERO,
        LUX_BASE,
        LUX_POLY
    } lux_src_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_DIV,
        DP_DIV_STEP,
        DP_X_A4,
        DP_X_H1,
        DP_X_G,
        DP_X_H3,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_FINAL
    } dp_op_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [RAW_W-1:0] raw_count;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [GAIN_W-1:0] gain_step;
        logic [TIME_W-1:0] time_step;
        logic [LUX_W-1:0]  lux_value;
        logic              was_corrected;
    } out_item_t;

    typedef struct packed {
        dp_op_t            op;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [GAIN_W-1:0] gain_step;
        logic [TIME_W-1:0] time_step;
        logic              corr;
        lux_src_t          lux_src;
    } dp_cmd_t;

    typedef struct packed {
        logic le_low;
        logic gt_high;
    } dp_status_t;

    // Gain step to extra resolution shift: 1/8, 1/4, 1, 2
    function automatic logic [SHIFT_W-1:0] gain_shift(input logic [GAIN_W-1:0] g);
        logic [SHIFT_W-1:0] s;
        case (g)
            2'd0:    s = 5'd4;
            2'd1:    s = 5'd3;
            2'd2:    s = 5'd1;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Radix-16 quotient digit of a partial remainder
    function automatic logic [DIG_W-1:0] div_digit(input logic [PART_W-1:0] part);
        logic [DIG_W-1:0] d;
        d = '0;
        for (int k = 1; k < (1 << DIG_W); k++) begin
            if (part >= PART_W'(k) * DIVISOR)
                d = DIG_W'(k);
        end
        return d;
    endfunction

    // Horner sequence: each product by base lux takes a low and a high pass
    function automatic dp_op_t poly_op(input logic [CNT_W-1:0] step);
        dp_op_t op;
        case (step)
            4'd0:    op = DP_X_A4;
            4'd1:    op = DP_MUL_LO;
            4'd2:    op = DP_MUL_HI;
            4'd3:    op = DP_X_H1;
            4'd4:    op = DP_MUL_LO;
            4'd5:    op = DP_MUL_HI;
            4'd6:    op = DP_X_G;
            4'd7:    op = DP_MUL_LO;
            4'd8:    op = DP_MUL_HI;
            4'd9:    op = DP_X_H3;
            4'd10:   op = DP_MUL_LO;
            4'd11:   op = DP_MUL_HI;
            4'd12:   op = DP_FINAL;
            default: op = DP_NOP;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lsar_dp.sv -----
// ---------------------------------------------------------------------------
// lsar_dp
// Datapath: threshold compares, radix-16 rounded divide by 10000, shared
// 44x18 Horner multiplier and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsar_dp (
    input  wire logic                        clk,
    input  wire lsar_pkg::dp_cmd_t           cmd,
    input  wire logic [lsar_pkg::RAW_W-1:0]  raw_count,
    input  wire logic [lsar_pkg::RAW_W-1:0]  low_limit,
    input  wire logic [lsar_pkg::RAW_W-1:0]  high_limit,
    output lsar_pkg::dp_status_t             status,
    output lsar_pkg::out_item_t              out_item
);
    import lsar_pkg::*;

    logic [RAW_W-1:0]        raw_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [REM_W-1:0]        rem_reg;
    logic signed [X_W-1:0]   x_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [LUX_W-1:0]        poly_reg;
    out_item_t               out_reg;

    logic [SCALED_W-1:0]     scaled;
    logic [SHIFT_W-1:0]      shift_amt;
    logic [NUM_W-1:0]        num_load;
    logic [PART_W-1:0]       part;
    logic [DIG_W-1:0]        digit;
    logic [REM_W-1:0]        rem_step;
    logic [L_W-1:0]          l_base;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]        prod_ext;
    logic [ACC_W-1:0]        h2_sum;
    logic [ACC_W-1:0]        h3_sum;
    logic [ACC_W-1:0]        fin_sum;
    logic [LUX_W-1:0]        lux_sel;

    // Threshold compares for the auto sequencer
    assign status.le_low  = (raw_reg <= low_limit);
    assign status.gt_high = (raw_reg > high_limit);

    // Numerator: 36 * raw scaled by 2^(s+16), plus half the divisor
    assign scaled    = (SCALED_W'(raw_reg) << 5) + (SCALED_W'(raw_reg) << 2);
    assign shift_amt = SHIFT_W'(TIME_MAX - cmd.time_step) + gain_shift(cmd.gain_step)
                       + Q16_SHIFT;
    assign num_load  = (NUM_W'(scaled) << shift_amt) + ROUND_BIAS;

    // One radix-16 long-division step
    assign part     = {rem_reg, num_reg[NUM_W-1 -: DIG_W]};
    assign digit    = div_digit(part);
    assign rem_step = REM_W'(part - PART_W'(digit) * DIVISOR);

    // Quotient is base lux once all digits are in
    assign l_base = num_reg[L_W-1:0];

    // Shared multiplier: coefficient times one half of base lux
    assign mul_b    = (cmd.op == DP_MUL_HI) ? $signed({1'b0, l_base[L_W-1:LO_W]})
                                            : $signed({2'b00, l_base[LO_W-1:0]});
    assign prod     = x_reg * mul_b;
    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    // Coefficient update sums
    assign h2_sum  = acc_reg + CA2;
    assign h3_sum  = acc_reg + CA1;
    assign fin_sum = acc_reg + FINAL_BIAS;

    // Pick the lux for the outgoing beat
    always_comb
    begin
        case (cmd.lux_src)
            LUX_BASE: lux_sel = LUX_W'(l_base);
            LUX_POLY: lux_sel = poly_reg;
            default:  lux_sel = '0;
        endcase
    end

    // Execute one datapath command
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                raw_reg <= raw_count;
            end
            DP_LOAD_DIV:
            begin
                num_reg <= num_load;
                rem_reg <= '0;
            end
            DP_DIV_STEP:
            begin
                num_reg <= {num_reg[NUM_W-DIG_W-1:0], digit};
                rem_reg <= rem_step;
            end
            DP_X_A4:
            begin
                x_reg <= CA4;
            end
            DP_X_H1:
            begin
                x_reg <= X_W'(acc_reg[H1_LSB +: 32]) - CA3;
            end
            DP_X_G:
            begin
                // Clamp a negative second Horner term to zero
                x_reg <= h2_sum[ACC_W-1] ? '0 : h2_sum[H2_LSB +: X_W];
            end
            DP_X_H3:
            begin
                x_reg <= h3_sum[H3_LSB +: X_W];
            end
            DP_MUL_LO:
            begin
                acc_reg <= prod_ext;
            end
            DP_MUL_HI:
            begin
                acc_reg <= acc_reg + {prod_ext[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
            end
            DP_FINAL:
            begin
                // Rounded Q16 result stays below 2^45, so no clamp engages
                poly_reg <= LUX_W'(fin_sum[ACC_W-1:FIN_LSB]);
            end
            default:
            begin
            end
        endcase
    end

    // Load the output register on an emitted beat
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.kind          <= cmd.kind;
            out_reg.gain_step     <= cmd.gain_step;
            out_reg.time_step     <= cmd.time_step;
            out_reg.lux_value     <= lux_sel;
            out_reg.was_corrected <= cmd.corr;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// ----- sv/lsar_ctrl.sv -----
// ---------------------------------------------------------------------------
// lsar_ctrl
// Controller: handshake, auto-ranging state and the command sequence for
// the divide and the correction polynomial.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "light_sensor_auto_range_lux_unit_assert.svh"

module lsar_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [lsar_pkg::OP_W-1:0]    operation,
    input  wire logic [lsar_pkg::GAIN_W-1:0]  manual_gain,
    input  wire logic [lsar_pkg::TIME_W-1:0]  manual_time,
    input  wire lsar_pkg::dp_status_t         status,
    output lsar_pkg::dp_cmd_t                 cmd,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import lsar_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    op_t                op_reg, op_next;
    phase_t             phase_reg, phase_next;
    logic [GAIN_W-1:0]  auto_gain_reg, auto_gain_next;
    logic [TIME_W-1:0]  auto_time_reg, auto_time_next;
    logic               auto_corr_reg, auto_corr_next;
    kind_t              res_kind_reg, res_kind_next;
    logic [GAIN_W-1:0]  res_gain_reg, res_gain_next;
    logic [TIME_W-1:0]  res_time_reg, res_time_next;
    logic               res_corr_reg, res_corr_next;
    lux_src_t           res_src_reg, res_src_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= OP_START_AUTO;
            phase_reg     <= PH_IDLE;
            auto_gain_reg <= GAIN_AUTO_START;
            auto_time_reg <= TIME_AUTO_START;
            auto_corr_reg <= 1'b0;
            res_kind_reg  <= KIND_APPLY;
            res_gain_reg  <= '0;
            res_time_reg  <= '0;
            res_corr_reg  <= 1'b0;
            res_src_reg   <= LUX_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            auto_gain_reg <= auto_gain_next;
            auto_time_reg <= auto_time_next;
            auto_corr_reg <= auto_corr_next;
            res_kind_reg  <= res_kind_next;
            res_gain_reg  <= res_gain_next;
            res_time_reg  <= res_time_next;
            res_corr_reg  <= res_corr_next;
            res_src_reg   <= res_src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state, auto-ranging decision and datapath commands
    always_comb
    begin
        phase_t phase_eff;
        logic   corr_eff;
        logic   conv;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        phase_next     = phase_reg;
        auto_gain_next = auto_gain_reg;
        auto_time_next = auto_time_reg;
        auto_corr_next = auto_corr_reg;
        res_kind_next  = res_kind_reg;
        res_gain_next  = res_gain_reg;
        res_time_next  = res_time_reg;
        res_corr_next  = res_corr_reg;
        res_src_next   = res_src_reg;
        phase_eff      = phase_reg;
        corr_eff       = auto_corr_reg;
        conv           = 1'b0;

        cmd.op        = DP_NOP;
        cmd.emit      = 1'b0;
        cmd.kind      = res_kind_reg;
        cmd.gain_step = res_gain_reg;
        cmd.time_step = res_time_reg;
        cmd.corr      = res_corr_reg;
        cmd.lux_src   = res_src_reg;

        // Drop the output beat once taken
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(operation);
                    cmd.op     = DP_CAPTURE;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (op_reg) inside
                    OP_START_AUTO:
                    begin
                        phase_next     = PH_FIRST;
                        auto_gain_next = GAIN_AUTO_START;
                        auto_time_next = TIME_AUTO_START;
                        auto_corr_next = 1'b0;
                        res_kind_next  = KIND_APPLY;
                        res_gain_next  = GAIN_AUTO_START;
                        res_time_next  = TIME_AUTO_START;
                        res_corr_next  = 1'b0;
                        res_src_next   = LUX_ZERO;
                    end
                    OP_MANUAL_PLAIN, OP_MANUAL_CORR:
                    begin
                        // Out-of-range time steps act as the longest time
                        conv          = 1'b1;
                        res_kind_next = KIND_LUX;
                        res_gain_next = manual_gain;
                        res_time_next = (manual_time > TIME_MAX) ? TIME_MAX : manual_time;
                        res_corr_next = (op_reg == OP_MANUAL_CORR);
                        res_src_next  = (op_reg == OP_MANUAL_CORR) ? LUX_POLY : LUX_BASE;
                    end
                    default:
                    begin
                        if (phase_reg == PH_IDLE)
                        begin
                            // Sample with no sequence running: reject
                            res_kind_next = KIND_REJECT;
                            res_gain_next = auto_gain_reg;
                            res_time_next = auto_time_reg;
                            res_corr_next = 1'b0;
                            res_src_next  = LUX_ZERO;
                        end
                        else
                        begin
                            // First reading picks the direction
                            if (phase_reg == PH_FIRST)
                            begin
                                if (status.le_low)
                                    phase_eff = PH_RAISE;
                                else
                                begin
                                    phase_eff = PH_SHORTEN;
                                    corr_eff  = 1'b1;
                                end
                            end
                            phase_next     = phase_eff;
                            auto_corr_next = corr_eff;
                            res_corr_next  = 1'b0;
                            res_src_next   = LUX_ZERO;
                            if (phase_eff == PH_RAISE && status.le_low &&
                                !(auto_gain_reg == GAIN_STEP_TOP && auto_time_reg == TIME_MAX))
                            begin
                                // Raise gain first, then integration time
                                res_kind_next = KIND_APPLY;
                                if (auto_gain_reg < GAIN_STEP_TOP)
                                begin
                                    auto_gain_next = auto_gain_reg + 1'b1;
                                    res_gain_next  = auto_gain_reg + 1'b1;
                                    res_time_next  = auto_time_reg;
                                end
                                else
                                begin
                                    auto_time_next = auto_time_reg + 1'b1;
                                    res_gain_next  = auto_gain_reg;
                                    res_time_next  = auto_time_reg + 1'b1;
                                end
                            end
                            else if (phase_eff == PH_SHORTEN && status.gt_high &&
                                     auto_time_reg != '0)
                            begin
                                // Shorten integration time
                                res_kind_next  = KIND_APPLY;
                                auto_time_next = auto_time_reg - 1'b1;
                                res_gain_next  = auto_gain_reg;
                                res_time_next  = auto_time_reg - 1'b1;
                            end
                            else
                            begin
                                // Settled: convert at the current steps
                                conv          = 1'b1;
                                phase_next    = PH_IDLE;
                                res_kind_next = KIND_LUX;
                                res_gain_next = auto_gain_reg;
                                res_time_next = auto_time_reg;
                                res_corr_next = corr_eff;
                                res_src_next  = corr_eff ? LUX_POLY : LUX_BASE;
                            end
                        end
                    end
                endcase
                state_next = conv ? ST_LOAD : ST_EMIT;
            end
            ST_LOAD:
            begin
                cmd.op     = DP_LOAD_DIV;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = res_corr_reg ? ST_POLY : ST_EMIT;
                end
            end
            ST_POLY:
            begin
                cmd.op   = poly_op(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == POLY_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LSAR_ASSERT_HOLDS(a_auto_time_range, auto_time_reg <= TIME_MAX, "auto time step out of range")
    `LSAR_ASSERT_NEXT(a_accept_decide, in_valid && in_ready, state_reg == ST_DECIDE, "accepted beat not decided")
    `LSAR_ASSERT_IMP(a_div_count, state_reg == ST_DIV, cnt_reg <= DIV_LAST, "divide step count overrun")
    `LSAR_ASSERT_IMP(a_emit_lux_src, cmd.emit, (cmd.kind == KIND_LUX) == (cmd.lux_src != LUX_ZERO), "lux source disagrees with kind")

endmodule

`default_nettype wire

// ----- sv/light_sensor_auto_range_lux_unit.sv -----
// Start, apply and reject results go from DECIDE to EMIT; lux results run LOAD and
// DIV first, corrected lux also POLY; a new beat is taken only back in IDLE.
// Plain lux uses the 12-step radix-16 divide by 10000; corrected lux adds 13 steps
// on the shared 44x18 multiplier (two passes per Horner product).
// Reset (rst_n low, asynchronous) clears the sequencer, the auto-ranging state and
// the output valid, and loads the configuration defaults; no memory to clear.
// ---------------------------------------------------------------------------
// light_sensor_auto_range_lux_unit
// Ambient-light count to Q32.16 lux converter with auto gain and time ranging.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module light_sensor_auto_range_lux_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire lsar_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output lsar_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_write,
    input  wire logic [lsar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsar_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsar_pkg::*;

    logic [GAIN_W-1:0] manual_gain_reg;
    logic [TIME_W-1:0] manual_time_reg;
    logic [RAW_W-1:0]  low_limit_reg;
    logic [RAW_W-1:0]  high_limit_reg;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_gain_reg <= CFG_GAIN_RST;
            manual_time_reg <= CFG_TIME_RST;
            low_limit_reg   <= CFG_LOW_RST;
            high_limit_reg  <= CFG_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MANUAL_GAIN: manual_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_MANUAL_TIME: manual_time_reg <= cfg_data[TIME_W-1:0];
                REG_LOW_LIMIT:   low_limit_reg   <= cfg_data[RAW_W-1:0];
                REG_HIGH_LIMIT:  high_limit_reg  <= cfg_data[RAW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lsar_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (in_item.operation),
        .manual_gain (manual_gain_reg),
        .manual_time (manual_time_reg),
        .status      (status),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    lsar_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .raw_count  (in_item.raw_count),
        .low_limit  (low_limit_reg),
        .high_limit (high_limit_reg),
        .status     (status),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - lux converter testbench
// Drives count beats into the auto-ranging lux converter and compares every
// result beat against an in-bench predictor (typed table rows give their own).
// A short table of directed beats comes first, then random auto-ranging sequences
// under several register settings, with random idling on both handshakes.
// ---------------------------------------------------------------------------
module tb;
    import lsar_pkg::*;

    localparam int          N_PROBES    = 24;
    localparam int          N_PHASES    = 10;
    localparam int          PHASE_BEATS = 93;
    localparam int          TOTAL_BEATS = N_PROBES + N_PHASES * PHASE_BEATS;
    localparam int          CALM_BEATS  = 90;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 40;
    localparam logic [1:0]  TOP_GAIN    = 2'd3;
    localparam logic [2:0]  TOP_TIME    = 3'd5;
    localparam logic [2:0]  START_TIME  = 3'd2;
    localparam logic [63:0] LUX_TOP     = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        op_t         op;
        logic [15:0] raw;
        logic        typed;
        out_item_t   want;
    } probe_row_t;

    // Directed beats; a typed row carries its own expected result
    localparam probe_row_t PROBES [N_PROBES] = '{
        '{OP_AUTO_SAMPLE,  16'h1234, 1'b1, '{KIND_REJECT, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_MANUAL_PLAIN, 16'h0000, 1'b1, '{KIND_LUX, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_MANUAL_PLAIN, 16'hFFFF, 1'b0, '0},
        '{OP_MANUAL_CORR,  16'h0000, 1'b1, '{KIND_LUX, 2'd0, 3'd2, 48'd0, 1'b1}},
        '{OP_MANUAL_CORR,  16'hFFFF, 1'b0, '0},
        '{OP_START_AUTO,   16'hFFFF, 1'b1, '{KIND_APPLY, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b1, '{KIND_LUX, 2'd3, 3'd5, 48'd0, 1'b0}},
        '{OP_START_AUTO,   16'h0000, 1'b1, '{KIND_APPLY, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_AUTO_SAMPLE,  16'hFFFF, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'hFFFF, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'hFFFF, 1'b0, '0},
        '{OP_START_AUTO,   16'h0000, 1'b1, '{KIND_APPLY, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_AUTO_SAMPLE,  16'h0000, 1'b0, '0},
        '{OP_START_AUTO,   16'h5A5A, 1'b1, '{KIND_APPLY, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_MANUAL_PLAIN, 16'h04D2, 1'b0, '0},
        '{OP_AUTO_SAMPLE,  16'h1388, 1'b0, '0},
        '{OP_START_AUTO,   16'h0000, 1'b1, '{KIND_APPLY, 2'd0, 3'd2, 48'd0, 1'b0}},
        '{OP_AUTO_SAMPLE,  16'h0064, 1'b0, '0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of configuration and ranging state
    logic [1:0]  cfg_gain  = 2'd0;
    logic [2:0]  cfg_time  = 3'd2;
    logic [15:0] cfg_low   = 16'd100;
    logic [15:0] cfg_high  = 16'd10000;
    phase_t      auto_ph   = PH_IDLE;
    logic [1:0]  auto_gain = 2'd0;
    logic [2:0]  auto_time = 3'd2;
    logic        auto_corr = 1'b0;

    out_item_t   lux_due[$];
    int          beats_sent  = 0;
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          calm_tail   = 1'b0;

    light_sensor_auto_range_lux_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Q16 lux from a raw count: 0.0036 * 2^shift * raw, rounded half up
    function automatic logic [63:0] scaled_lux(logic [15:0] raw, logic [1:0] g,
                                               logic [2:0] t);
        int          sh;
        logic [63:0] num;
        case (g)
            2'd0:    sh = 4;
            2'd1:    sh = 3;
            2'd2:    sh = 1;
            default: sh = 0;
        endcase
        sh  = sh + 5 - int'(t);
        num = (64'd36 * 64'(raw)) << (sh + 16);
        return (num + 64'd5000) / 64'd10000;
    endfunction

    // Quartic correction in Horner form, fixed point, truncating shifts
    function automatic logic [63:0] linearize_lux(logic [63:0] lin);
        longint      h1;
        longint      h2;
        logic [63:0] h3;
        logic [63:0] acc;
        acc = (64'd693309 * lin) >> 32;
        h1  = longint'(acc) - 64'sd165233;
        h2  = 64'sd93949267567403 + h1 * longint'(lin);
        if (h2 < 0)
            h2 = 0;
        h3  = (($unsigned(h2) >> 28) * lin + 64'd282122369157091) >> 16;
        acc = h3 * (lin >> 16) + ((h3 * (lin & 64'hFFFF)) >> 16);
        acc = (acc + 64'h8000) >> 16;
        return (acc > LUX_TOP) ? LUX_TOP : acc;
    endfunction

    function automatic out_item_t make_result(kind_t k, logic [1:0] g, logic [2:0] t,
                                              logic [15:0] raw, logic corr);
        out_item_t   r;
        logic [63:0] lux;
        lux = 64'd0;
        if (k == KIND_LUX) begin
            lux = scaled_lux(raw, g, t);
            if (corr)
                lux = linearize_lux(lux);
            if (lux > LUX_TOP)
                lux = LUX_TOP;
        end else begin
            corr = 1'b0;
        end
        r.kind          = k;
        r.gain_step     = g;
        r.time_step     = t;
        r.lux_value     = lux[47:0];
        r.was_corrected = corr;
        return r;
    endfunction

    // Advance the ranging state for one beat and return its result
    function automatic out_item_t predict_reading(op_t op, logic [15:0] raw);
        logic [2:0] t;
        case (op)
            OP_START_AUTO: begin
                auto_ph   = PH_FIRST;
                auto_gain = 2'd0;
                auto_time = START_TIME;
                auto_corr = 1'b0;
                return make_result(KIND_APPLY, 2'd0, START_TIME, 16'd0, 1'b0);
            end
            OP_MANUAL_PLAIN, OP_MANUAL_CORR: begin
                t = (cfg_time > TOP_TIME) ? TOP_TIME : cfg_time;
                return make_result(KIND_LUX, cfg_gain, t, raw, op == OP_MANUAL_CORR);
            end
            default: ;
        endcase
        if (auto_ph == PH_IDLE)
            return make_result(KIND_REJECT, auto_gain, auto_time, 16'd0, 1'b0);
        if (auto_ph == PH_FIRST) begin
            if (raw <= cfg_low) begin
                auto_ph = PH_RAISE;
            end else begin
                auto_ph   = PH_SHORTEN;
                auto_corr = 1'b1;
            end
        end
        if (auto_ph == PH_RAISE) begin
            if (raw <= cfg_low && !(auto_gain == TOP_GAIN && auto_time == TOP_TIME)) begin
                if (auto_gain < TOP_GAIN)
                    auto_gain++;
                else
                    auto_time++;
                return make_result(KIND_APPLY, auto_gain, auto_time, 16'd0, 1'b0);
            end
        end else if (raw > cfg_high && auto_time != 3'd0) begin
            auto_time--;
            return make_result(KIND_APPLY, auto_gain, auto_time, 16'd0, 1'b0);
        end
        auto_ph = PH_IDLE;
        return make_result(KIND_LUX, auto_gain, auto_time, raw, auto_corr);
    endfunction

    // Count biased around the thresholds; mode 0 leans low, 1 leans high
    function automatic logic [15:0] pick_count(int mode);
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cfg_low;
            3:       return cfg_low + 16'd1;
            4:       return cfg_high;
            5:       return cfg_high + 16'd1;
            default: begin
                if (mode == 0)
                    return 16'($urandom_range(cfg_low));
                if (mode == 1)
                    return 16'($urandom_range(65535, cfg_high));
                return 16'($urandom);
            end
        endcase
    endfunction

    // Send one beat, with an occasional idle burst ahead of it
    task automatic send_beat(op_t op, logic [15:0] raw, logic typed, out_item_t want);
        out_item_t guess;
        if (!calm_tail && $urandom_range(5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.operation <= op;
        in_item.raw_count <= raw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = predict_reading(op, raw);
        lux_due.push_back(typed ? want : guess);
        beats_sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            REG_MANUAL_GAIN: cfg_gain = d[1:0];
            REG_MANUAL_TIME: cfg_time = d[2:0];
            REG_LOW_LIMIT:   cfg_low  = d;
            REG_HIGH_LIMIT:  cfg_high = d;
            default: ;
        endcase
    endtask

    // Drain all results, then load the settings of phase k
    task automatic configure(int k);
        logic [1:0]  g;
        logic [2:0]  t;
        logic [15:0] lo;
        logic [15:0] hi;
        g  = (k < 4) ? 2'(k) : 2'($urandom);
        t  = (k < 8) ? 3'(k) : 3'($urandom);
        lo = (k == 1) ? 16'h0000 : (k == 2) ? 16'hFFFF : 16'($urandom_range(3000));
        hi = (k == 3) ? 16'h0000 : (k == 4) ? 16'hFFFF : 16'($urandom_range(65535, 2000));
        in_valid <= 1'b0;
        while (lux_due.size() != 0)
            @(posedge clk);
        write_reg(REG_MANUAL_GAIN, {14'($urandom), g});
        write_reg(REG_MANUAL_TIME, {13'($urandom), t});
        write_reg(REG_LOW_LIMIT, lo);
        write_reg(REG_HIGH_LIMIT, hi);
        cfg_write <= 1'b0;
    endtask

    // Stimulus: reset, directed table, then random phases
    initial begin : stimulus
        int mode;
        int n;
        int phase_end;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_PROBES; i++)
            send_beat(PROBES[i].op, PROBES[i].raw, PROBES[i].typed, PROBES[i].want);
        for (int k = 0; k < N_PHASES; k++) begin
            configure(k);
            phase_end = N_PROBES + (k + 1) * PHASE_BEATS;
            while (beats_sent < phase_end) begin
                if (beats_sent >= TOTAL_BEATS - CALM_BEATS)
                    calm_tail = 1'b1;
                if ($urandom_range(9) < 7) begin
                    // well-formed ranging run, now and then a manual beat inside
                    mode = $urandom_range(2);
                    n    = $urandom_range(9, 1);
                    send_beat(OP_START_AUTO, 16'($urandom), 1'b0, '0);
                    repeat (n) begin
                        if ($urandom_range(11) == 0)
                            send_beat($urandom_range(1) ? OP_MANUAL_CORR : OP_MANUAL_PLAIN,
                                      16'($urandom), 1'b0, '0);
                        send_beat(OP_AUTO_SAMPLE, pick_count(mode), 1'b0, '0);
                    end
                end else begin
                    send_beat(op_t'($urandom_range(3)), 16'($urandom), 1'b0, '0);
                end
            end
        end
        in_valid <= 1'b0;
        while (lux_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver stalls in random bursts, none in the calm tail
    initial begin : result_sink
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!calm_tail && $urandom_range(7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(9, 1)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (lux_due.size() == 0) begin
                $error("result beat with nothing expected: %p", out_item);
                fail_count++;
            end else begin
                want = lux_due.pop_front();
                check_field("kind", 64'(want.kind), 64'(out_item.kind));
                check_field("gain_step", 64'(want.gain_step), 64'(out_item.gain_step));
                check_field("time_step", 64'(want.time_step), 64'(out_item.time_step));
                check_field("lux_value", 64'(want.lux_value), 64'(out_item.lux_value));
                check_field("was_corrected", 64'(want.was_corrected),
                            64'(out_item.was_corrected));
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles == STALL_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/lsar_pkg.sv
sv/lsar_dp.sv
sv/lsar_ctrl.sv
sv/light_sensor_auto_range_lux_unit.sv
test/tb.sv
